// ===== src/nms_pkg.sv =====
// Shared types, constants and a helper function for the edge non-max suppression block.
package nms_pkg;

	// Frame geometry limits
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 4096;
	localparam int WIDTH_BITS  = $clog2(MAX_WIDTH + 1);
	localparam int HEIGHT_BITS = $clog2(MAX_HEIGHT + 1);
	localparam int COL_BITS    = $clog2(MAX_WIDTH);
	localparam int ROW_BITS    = $clog2(MAX_HEIGHT);

	localparam logic [WIDTH_BITS-1:0]  MAX_W_V     = WIDTH_BITS'(MAX_WIDTH);
	localparam logic [HEIGHT_BITS-1:0] MAX_H_V     = HEIGHT_BITS'(MAX_HEIGHT);
	localparam logic [WIDTH_BITS-1:0]  MIN_W_V     = WIDTH_BITS'(3);
	localparam logic [HEIGHT_BITS-1:0] MIN_H_V     = HEIGHT_BITS'(3);
	localparam logic [WIDTH_BITS-1:0]  RESET_WIDTH  = WIDTH_BITS'(640);
	localparam logic [HEIGHT_BITS-1:0] RESET_HEIGHT = HEIGHT_BITS'(480);

	// Payload widths
	localparam int MAG_BITS   = 16;
	localparam int ANGLE_BITS = 15;
	localparam int SEC_BITS   = 2;

	// Configuration port
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = HEIGHT_BITS;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Request kinds
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	// Direction sectors
	localparam logic [SEC_BITS-1:0] SEC_HORZ    = 2'd0;
	localparam logic [SEC_BITS-1:0] SEC_DIAG45  = 2'd1;
	localparam logic [SEC_BITS-1:0] SEC_VERT    = 2'd2;
	localparam logic [SEC_BITS-1:0] SEC_DIAG135 = 2'd3;

	// Q3.12 angle constants
	localparam logic signed [ANGLE_BITS:0] PI_Q12 = 16'sd12868;
	localparam logic signed [ANGLE_BITS:0] TH_22  = 16'sd1608;
	localparam logic signed [ANGLE_BITS:0] TH_67  = 16'sd4825;
	localparam logic signed [ANGLE_BITS:0] TH_112 = 16'sd8042;
	localparam logic signed [ANGLE_BITS:0] TH_157 = 16'sd11259;

	// Result queue sizing; ready holds while fewer than RES_LIMIT results are pending
	localparam int RES_DEPTH    = 4;
	localparam int RES_PTR_BITS = $clog2(RES_DEPTH);
	localparam int RES_CNT_BITS = $clog2(RES_DEPTH + 1);
	localparam logic [RES_CNT_BITS-1:0] RES_LIMIT = RES_CNT_BITS'(RES_DEPTH - 1);

	// One line memory word: upper row, middle row and the sector of the middle row
	typedef struct packed {
		logic [MAG_BITS-1:0] top;
		logic [MAG_BITS-1:0] mid;
		logic [SEC_BITS-1:0] sector;
	} line_entry_t;

	typedef struct packed {
		logic [MAG_BITS-1:0] mag;
		logic                last;
	} result_t;

	// Fold the direction into 0..pi and pick the sector
	function automatic logic [SEC_BITS-1:0] angle_sector(input logic signed [ANGLE_BITS-1:0] ang);
		logic signed [ANGLE_BITS:0] a;
		logic [SEC_BITS-1:0] sec;
		a = {ang[ANGLE_BITS-1], ang};
		if (a < 0) a = a + PI_Q12;
		if (a < 0 || a > PI_Q12) sec = SEC_HORZ;
		else if (a < TH_22)       sec = SEC_HORZ;
		else if (a < TH_67)       sec = SEC_DIAG45;
		else if (a < TH_112)      sec = SEC_VERT;
		else if (a < TH_157)      sec = SEC_DIAG135;
		else                      sec = SEC_HORZ;
		return sec;
	endfunction

endpackage

// ===== src/nms_pix_if.sv =====
// Input channel: pixel and flush items with valid/ready handshake.
interface nms_pix_if;
	logic                                    valid;
	logic                                    ready;
	logic                                    req_type;
	logic        [nms_pkg::MAG_BITS-1:0]     grad_magnitude;
	logic signed [nms_pkg::ANGLE_BITS-1:0]   grad_angle;

	modport source (output valid, output req_type, output grad_magnitude, output grad_angle,
		input ready);
	modport sink (input valid, input req_type, input grad_magnitude, input grad_angle,
		output ready);
endinterface

// ===== src/nms_res_if.sv =====
// Output channel: thinned magnitude items with valid/ready handshake.
interface nms_res_if;
	logic                           valid;
	logic                           ready;
	logic [nms_pkg::MAG_BITS-1:0]   thinned_magnitude;
	logic                           frame_last;

	modport source (output valid, output thinned_magnitude, output frame_last, input ready);
	modport sink (input valid, input thinned_magnitude, input frame_last, output ready);
endinterface

// ===== src/edge_non_max_suppression.sv =====
// Top level: Canny non-maximum suppression over a raster stream of gradient items.
//
// pix_in carries pixel items (gradient magnitude and Q2.12 direction) and flush
// items; res_out carries thinned magnitudes with frame_last on the last result of
// a frame. cfg_we/cfg_index/cfg_data set image_width and image_height; a write
// restarts the frame. The user writes only while the block is idle; it is not enforced.
// Throughput: one item per clock while ready is high. Each accepted pixel does
// one read of the line memory at its column and one write-back of the same word
// in the next cycle, and that single read-modify-write per cycle sets the rate.
// Path: an accepted item is registered in stage 1, and its result is pushed into the
// result queue and leaves from there. A pixel's result belongs to the pixel width+1
// items earlier; border pixels give 0. After the last pixel of a frame width+1 zeros
// are owed and come out on flush items or on the first pixels of the next frame.
// Reset: geometry returns to 640 x 480, counters, window and owed count clear.
// The line memory is not cleared; unwritten words reach only border results.
// Stall: a four-entry result queue absorbs work in flight; pix_in.ready drops once
// three results are pending and the input side simply waits.
module edge_non_max_suppression (
	input  logic                               clk,
	input  logic                               arst_n,
	nms_pix_if.sink                            pix_in,
	nms_res_if.source                          res_out,
	input  logic                               cfg_we,
	input  logic [nms_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [nms_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	// Geometry registers and clamped geometry
	logic [nms_pkg::WIDTH_BITS-1:0]  width_q, eff_w;
	logic [nms_pkg::HEIGHT_BITS-1:0] height_q, eff_h;

	always_comb begin
		if (width_q < nms_pkg::MIN_W_V)      eff_w = nms_pkg::MIN_W_V;
		else if (width_q > nms_pkg::MAX_W_V) eff_w = nms_pkg::MAX_W_V;
		else                                 eff_w = width_q;
		if (height_q < nms_pkg::MIN_H_V)      eff_h = nms_pkg::MIN_H_V;
		else if (height_q > nms_pkg::MAX_H_V) eff_h = nms_pkg::MAX_H_V;
		else                                  eff_h = height_q;
	end

	// Position and owed-result counters
	logic [nms_pkg::COL_BITS-1:0]   col_q;
	logic [nms_pkg::ROW_BITS-1:0]   row_q;
	logic [nms_pkg::WIDTH_BITS-1:0] owed_q;

	// Stage 1 and result queue
	logic                              v_s1, pix_s1, emit_s1, zero_s1, last_s1;
	logic [nms_pkg::COL_BITS-1:0]      addr_s1;
	logic [nms_pkg::MAG_BITS-1:0]      mag_s1;
	logic [nms_pkg::SEC_BITS-1:0]      sec_s1;
	logic [nms_pkg::RES_CNT_BITS-1:0]  res_cnt_q, pending;
	logic [nms_pkg::RES_PTR_BITS-1:0]  res_wr_q, res_rd_q;
	nms_pkg::result_t                  res_mem_q [nms_pkg::RES_DEPTH];

	// Accept side
	logic acc, is_pix;
	assign pending      = res_cnt_q + nms_pkg::RES_CNT_BITS'(v_s1);
	assign pix_in.ready = pending < nms_pkg::RES_LIMIT;
	assign acc          = pix_in.valid && pix_in.ready;
	assign is_pix       = pix_in.req_type == nms_pkg::REQ_PIXEL;

	// Position decode for the incoming pixel
	logic [nms_pkg::WIDTH_BITS-1:0]  x_w, col_next, cx;
	logic [nms_pkg::HEIGHT_BITS-1:0] y_h, cy;
	logic emit_pix, border, row_end, frame_end, owed_any, owed_one;

	always_comb begin
		x_w       = nms_pkg::WIDTH_BITS'(col_q);
		y_h       = nms_pkg::HEIGHT_BITS'(row_q);
		col_next  = x_w + 1'b1;
		row_end   = col_next >= eff_w;
		frame_end = (y_h == eff_h - 1'b1) && (x_w == eff_w - 1'b1);
		emit_pix  = (y_h >= nms_pkg::HEIGHT_BITS'(2)) ||
			((y_h == nms_pkg::HEIGHT_BITS'(1)) && (x_w != '0));
		// centre sits one pixel back and one row up, or at column 0 at the end of row y-2
		if (x_w != '0) begin
			cx = x_w - 1'b1;
			cy = y_h - 1'b1;
		end else begin
			cx = eff_w - 1'b1;
			cy = y_h - nms_pkg::HEIGHT_BITS'(2);
		end
		border   = (cy == '0) || (cy >= eff_h - 1'b1) || (cx == '0) || (cx >= eff_w - 1'b1);
		owed_any = owed_q != '0;
		owed_one = owed_q == nms_pkg::WIDTH_BITS'(1);
	end

	// Configuration and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= nms_pkg::RESET_WIDTH;
			height_q <= nms_pkg::RESET_HEIGHT;
			col_q    <= '0;
			row_q    <= '0;
			owed_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				nms_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[nms_pkg::WIDTH_BITS-1:0];
				nms_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
			col_q  <= '0;
			row_q  <= '0;
			owed_q <= '0;
		end else if (acc) begin
			if (is_pix) begin
				col_q <= row_end ? '0 : col_next[nms_pkg::COL_BITS-1:0];
				if (frame_end)    row_q <= '0;
				else if (row_end) row_q <= row_q + 1'b1;
				if (emit_pix) begin
					if (frame_end) owed_q <= eff_w + 1'b1;
				end else if (owed_any) begin
					owed_q <= owed_q - 1'b1;
				end
			end else if (owed_any) begin
				owed_q <= owed_q - 1'b1;
			end
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= is_pix;
			emit_s1 <= (is_pix && emit_pix) || owed_any;
			zero_s1 <= !is_pix || !emit_pix || border;
			last_s1 <= (!is_pix || !emit_pix) && owed_one;
			addr_s1 <= col_q;
			mag_s1  <= pix_in.grad_magnitude;
			sec_s1  <= nms_pkg::angle_sector(pix_in.grad_angle);
		end
	end

	// Line memory: read at accept, write back the shifted rows in the next cycle
	nms_pkg::line_entry_t line_mem [nms_pkg::MAX_WIDTH];
	nms_pkg::line_entry_t rd_q, wr_word;
	logic ram_re, ram_we;

	assign ram_re  = acc && is_pix;
	assign ram_we  = v_s1 && pix_s1;
	assign wr_word = '{top: rd_q.mid, mid: mag_s1, sector: sec_s1};

	always_ff @(posedge clk) begin
		if (ram_we) line_mem[addr_s1] <= wr_word;
		if (ram_re) rd_q <= line_mem[col_q];
	end

	// 3x3 window and delayed centre sector
	logic [nms_pkg::MAG_BITS-1:0] taps_q [9];
	logic [nms_pkg::MAG_BITS-1:0] taps_n [9];
	logic [nms_pkg::SEC_BITS-1:0] sec_hold_q;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			taps_n[k*3]     = taps_q[k*3 + 1];
			taps_n[k*3 + 1] = taps_q[k*3 + 2];
		end
		taps_n[2] = rd_q.top;
		taps_n[5] = rd_q.mid;
		taps_n[8] = mag_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) taps_q[k] <= '0;
			sec_hold_q <= nms_pkg::SEC_HORZ;
		end else if (ram_we) begin
			for (int k = 0; k < 9; k++) taps_q[k] <= taps_n[k];
			sec_hold_q <= rd_q.sector;
		end
	end

	// Compare centre with its two neighbors along the sector
	logic [nms_pkg::MAG_BITS-1:0] nb_q, nb_r, res_mag;
	always_comb begin
		unique case (sec_hold_q)
			nms_pkg::SEC_HORZ:   begin nb_q = taps_n[5]; nb_r = taps_n[3]; end
			nms_pkg::SEC_DIAG45: begin nb_q = taps_n[6]; nb_r = taps_n[2]; end
			nms_pkg::SEC_VERT:   begin nb_q = taps_n[7]; nb_r = taps_n[1]; end
			default:             begin nb_q = taps_n[0]; nb_r = taps_n[8]; end
		endcase
		if (zero_s1 || taps_n[4] < nb_q || taps_n[4] < nb_r) res_mag = '0;
		else                                                 res_mag = taps_n[4];
	end

	// Result queue
	logic push, pop;
	assign push = v_s1 && emit_s1;
	assign pop  = res_out.valid && res_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= '0;
			res_wr_q  <= '0;
			res_rd_q  <= '0;
		end else begin
			if (push) res_wr_q <= res_wr_q + 1'b1;
			if (pop)  res_rd_q <= res_rd_q + 1'b1;
			if (push && !pop)      res_cnt_q <= res_cnt_q + 1'b1;
			else if (pop && !push) res_cnt_q <= res_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) res_mem_q[res_wr_q] <= '{mag: res_mag, last: last_s1};
	end

	assign res_out.valid             = res_cnt_q != '0;
	assign res_out.thinned_magnitude = res_mem_q[res_rd_q].mag;
	assign res_out.frame_last        = res_mem_q[res_rd_q].last;

	// Checks
	a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_re && ram_we) |-> (col_q != addr_s1))
		else $error("line memory read and write-back hit the same column");

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (res_cnt_q < nms_pkg::RES_CNT_BITS'(nms_pkg::RES_DEPTH)))
		else $error("result queue overflow");

	a_owed_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_pix && emit_pix && frame_end && !cfg_we) |=>
		(owed_q == $past(eff_w) + 1'b1))
		else $error("owed count not loaded at frame end");

endmodule
